FILE: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the round-robin task slot scheduler.
// No dependencies; every other file of the block imports this package.
package rrts_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W   = 48;
    localparam int MODE_W    = 2;
    localparam int CODE_W    = 2;
    localparam int ID_W      = 2;

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = ((MODE_W + ENTRY_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((CODE_W + ID_W + ENTRY_W + 1 + ID_W + 7) / 8) * 8;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_YIELD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TERM   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Result status codes.
    localparam logic [CODE_W-1:0] RES_OK         = 2'd0;
    localparam logic [CODE_W-1:0] RES_NO_FREE    = 2'd1;
    localparam logic [CODE_W-1:0] RES_NO_READY   = 2'd2;
    localparam logic [CODE_W-1:0] RES_NO_CURRENT = 2'd3;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_TERM    = 2'd3
    } slot_state_t;

    // Decision of the slot controller for one request.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SLOT_W-1:0] slot_id;
        logic              dispatch;
        logic              run_valid;
        logic [SLOT_W-1:0] run_id;
        logic              wr_en;
        logic              rd_en;
        logic [SLOT_W-1:0] addr;
    } dec_t;

endpackage

FILE: rtl/rrts_entry_ram.sv
`timescale 1ns / 1ps
// Entry address store of the task slot table: one write port, one read port,
// registered read data. Depends on rrts_pkg.
module rrts_entry_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [rrts_pkg::SLOT_W-1:0]   wr_addr,
    input  logic [rrts_pkg::ENTRY_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [rrts_pkg::SLOT_W-1:0]   rd_addr,
    output logic [rrts_pkg::ENTRY_W-1:0]  rd_data
);
    import rrts_pkg::*;

    logic [ENTRY_W-1:0] mem [NUM_SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/rrts_slot_ctrl.sv
`timescale 1ns / 1ps
// Slot status table, current task register and the create/yield/terminate
// decision logic of the scheduler. Depends on rrts_pkg.
module rrts_slot_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    input  logic [rrts_pkg::MODE_W-1:0]  req_mode,
    output rrts_pkg::dec_t               dec
);
    import rrts_pkg::*;

    slot_state_t       status_reg  [NUM_SLOTS];
    slot_state_t       status_next [NUM_SLOTS];
    logic              cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;

    logic              free_found, ready_found, rr_found, pick_found, run_found;
    logic [SLOT_W-1:0] free_idx, ready_idx, rr_idx, pick_idx, run_idx;

    // Lowest unused and lowest ready slot.
    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        ready_found = 1'b0;
        ready_idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!free_found && status_reg[i] == ST_UNUSED) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (!ready_found && status_reg[i] == ST_READY) begin
                ready_found = 1'b1;
                ready_idx   = SLOT_W'(i);
            end
        end
    end

    // Round-robin search starting after the current slot; the current slot
    // itself is never a candidate.
    always_comb begin
        logic [SLOT_W:0] sum;
        rr_found = 1'b0;
        rr_idx   = '0;
        sum      = '0;
        for (int k = 1; k < NUM_SLOTS; k++) begin
            sum = {1'b0, cur_slot_reg} + (SLOT_W+1)'(k);
            if (sum >= (SLOT_W+1)'(NUM_SLOTS)) begin
                sum = sum - (SLOT_W+1)'(NUM_SLOTS);
            end
            if (!rr_found && status_reg[sum[SLOT_W-1:0]] == ST_READY) begin
                rr_found = 1'b1;
                rr_idx   = sum[SLOT_W-1:0];
            end
        end
    end

    assign pick_found = cur_valid_reg ? rr_found : ready_found;
    assign pick_idx   = cur_valid_reg ? rr_idx : ready_idx;

    always_comb begin
        status_next    = status_reg;
        cur_valid_next = cur_valid_reg;
        cur_slot_next  = cur_slot_reg;
        dec            = '0;
        unique case (req_mode)
            MODE_CREATE: begin
                if (free_found) begin
                    status_next[free_idx] = ST_READY;
                    dec.wr_en   = 1'b1;
                    dec.addr    = free_idx;
                    dec.slot_id = free_idx;
                end else begin
                    dec.code = RES_NO_FREE;
                end
            end
            MODE_YIELD, MODE_TERM: begin
                if (req_mode == MODE_TERM && !cur_valid_reg) begin
                    dec.code = RES_NO_CURRENT;
                end else begin
                    if (req_mode == MODE_TERM) begin
                        status_next[cur_slot_reg] = ST_TERM;
                    end
                    if (pick_found) begin
                        // A terminated current slot is not demoted.
                        if (cur_valid_reg && status_next[cur_slot_reg] == ST_RUNNING) begin
                            status_next[cur_slot_reg] = ST_READY;
                        end
                        status_next[pick_idx] = ST_RUNNING;
                        cur_valid_next = 1'b1;
                        cur_slot_next  = pick_idx;
                        dec.rd_en      = 1'b1;
                        dec.addr       = pick_idx;
                        dec.slot_id    = pick_idx;
                        dec.dispatch   = 1'b1;
                    end else begin
                        dec.code = RES_NO_READY;
                    end
                end
            end
            MODE_NONE: begin
            end
            default: begin
            end
        endcase
        dec.run_valid = run_found;
        dec.run_id    = run_idx;
    end

    // Lowest running slot after this request.
    always_comb begin
        run_found = 1'b0;
        run_idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!run_found && status_next[i] == ST_RUNNING) begin
                run_found = 1'b1;
                run_idx   = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                status_reg[i] <= ST_UNUSED;
            end
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
        end else if (req_valid) begin
            status_reg    <= status_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
        end
    end

endmodule

FILE: rtl/round_robin_task_slot_scheduler.sv
`timescale 1ns / 1ps
// Round-robin task slot scheduler, top level. A request is decided on its transfer, the entry
// address memory is read, and the result then moves to the output register. A new request is
// taken only after that, and later while an older result waits in the output register.
// aresetn (synchronous, active low) marks every slot unused, clears the current task and
// empties the output register; entry addresses are not cleared. Uses rrts_pkg,
// rrts_slot_ctrl and rrts_entry_ram.
module round_robin_task_slot_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: mode [1:0], entry_address [49:2], zero padding above.
    input  logic [rrts_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status [1:0], slot_id [3:2], dispatch_entry [51:4],
    // running_valid [52], running_id [54:53], zero padding above.
    output logic [rrts_pkg::M_DATA_W-1:0]   m_tdata
);
    import rrts_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t             state_reg;
    logic               in_xfer;
    logic [MODE_W-1:0]  in_mode;
    logic [ENTRY_W-1:0] in_entry;
    dec_t               dec;
    logic [ENTRY_W-1:0] ram_rd_data;

    // Decision held between the request transfer and the memory read result.
    logic [CODE_W-1:0]  code_reg;
    logic [SLOT_W-1:0]  id_reg;
    logic               disp_reg;
    logic               run_valid_reg;
    logic [SLOT_W-1:0]  run_id_reg;

    // Output register.
    logic               m_tvalid_reg;
    logic [CODE_W-1:0]  m_code_reg;
    logic [ID_W-1:0]    m_id_reg;
    logic [ENTRY_W-1:0] m_entry_reg;
    logic               m_run_valid_reg;
    logic [ID_W-1:0]    m_run_id_reg;
    logic               out_free;

    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_entry = s_tdata[MODE_W +: ENTRY_W];

    // Requests are taken only in IDLE, so one request is in flight at a time;
    // a result still waiting in the output register does not block a new one.
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // The status table is updated on the request transfer itself; the entry
    // memory is written on create or read for the dispatched slot in the same
    // cycle, and its read data is registered.
    rrts_slot_ctrl u_slot_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (in_xfer),
        .req_mode  (in_mode),
        .dec       (dec)
    );

    rrts_entry_ram u_entry_ram (
        .aclk    (aclk),
        .wr_en   (in_xfer && dec.wr_en),
        .wr_addr (dec.addr),
        .wr_data (in_entry),
        .rd_en   (in_xfer && dec.rd_en),
        .rd_addr (dec.addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In RESP the output register is either refilled below or still
            // held by a stalled receiver, so it only drains in the other state.
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        code_reg      <= dec.code;
                        id_reg        <= dec.slot_id;
                        disp_reg      <= dec.dispatch;
                        run_valid_reg <= dec.run_valid;
                        run_id_reg    <= dec.run_id;
                        state_reg     <= S_RESP;
                    end
                end
                S_RESP: begin
                    // The memory read data holds until the next read, so the
                    // result may wait here for the output register to drain.
                    if (out_free) begin
                        m_tvalid_reg    <= 1'b1;
                        m_code_reg      <= code_reg;
                        m_id_reg        <= ID_W'(id_reg);
                        m_entry_reg     <= disp_reg ? ram_rd_data : '0;
                        m_run_valid_reg <= run_valid_reg;
                        m_run_id_reg    <= ID_W'(run_id_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_run_id_reg, m_run_valid_reg, m_entry_reg,
                                 m_id_reg, m_code_reg});

    // A request transfer is always followed by a cycle with s_tready low.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // A failed request reports slot zero and no dispatch address.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != RES_OK) |->
            (m_tdata[3:2] == '0) && (m_tdata[51:4] == '0))
        else $error("failed request reports a slot or entry");

    // A dispatch reports a running slot equal to the dispatched slot.
    a_dispatch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == RES_OK) && (m_tdata[51:4] != '0) |->
            m_tdata[52] && (m_tdata[54:53] == m_tdata[3:2]))
        else $error("dispatched slot is not the running slot");

    // The entry memory is never written and read in the same cycle.
    a_ram_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> !(dec.wr_en && dec.rd_en))
        else $error("entry memory written and read together");

endmodule

FILE: tb/tb_round_robin_task_slot_scheduler.sv
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_task_slot_scheduler: directed and random requests,
// a cycle-accurate-free slot table predictor and a stream scoreboard on the result channel.
// Depends on rrts_pkg and the scheduler RTL only.
module tb_round_robin_task_slot_scheduler;

    import rrts_pkg::*;

    // A generous bound on the whole run; the slowest correct run needs far fewer cycles.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_REQS  = 600;
    localparam int PHASE_LEN    = 50;
    localparam int DRAIN_CYCLES = 8;

    // One result transfer, split into its fields.
    typedef struct packed {
        logic [CODE_W-1:0]  status;
        logic [ID_W-1:0]    slot_id;
        logic [ENTRY_W-1:0] dispatch_entry;
        logic               running_valid;
        logic [ID_W-1:0]    running_id;
    } sched_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // s_tdata: mode [1:0], entry_address [49:2], zero padding above.
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // m_tdata: status [1:0], slot_id [3:2], dispatch_entry [51:4],
    // running_valid [52], running_id [54:53], zero padding above.
    logic [M_DATA_W-1:0] m_tdata;

    round_robin_task_slot_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor copy of the slot table and the current task.
    slot_state_t        slot_st   [NUM_SLOTS];
    logic [ENTRY_W-1:0] slot_addr [NUM_SLOTS];
    logic               cur_valid;
    logic [SLOT_W-1:0]  cur_slot;

    logic [S_DATA_W-1:0] pending_reqs[$];
    sched_res_t          expected_results[$];

    int   total_reqs = 0;
    int   accepted_cnt = 0;
    int   err_cnt = 0;
    int   cycle_cnt = 0;
    int   idle_phase = 0;
    logic s_taken = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Works out the result of one request and advances the slot table.
    function automatic sched_res_t predict_sched(logic [MODE_W-1:0] mode,
                                                 logic [ENTRY_W-1:0] addr);
        sched_res_t r;
        int         pick;
        int         idx;
        logic       go;
        r    = '0;
        pick = -1;
        go   = 1'b0;
        case (mode)
            MODE_CREATE: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pick < 0 && slot_st[i] == ST_UNUSED) pick = i;
                end
                if (pick < 0) begin
                    r.status = RES_NO_FREE;
                end else begin
                    slot_addr[pick] = addr;
                    slot_st[pick]   = ST_READY;
                    r.slot_id       = ID_W'(pick);
                end
                pick = -1;
            end
            MODE_YIELD: go = 1'b1;
            MODE_TERM: begin
                if (!cur_valid) begin
                    r.status = RES_NO_CURRENT;
                end else begin
                    slot_st[cur_slot] = ST_TERM;
                    go = 1'b1;
                end
            end
            default: ;
        endcase
        if (go) begin
            if (!cur_valid) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pick < 0 && slot_st[i] == ST_READY) pick = i;
                end
            end else begin
                // Round-robin search that starts after the current slot and never picks it.
                for (int k = 1; k < NUM_SLOTS; k++) begin
                    idx = (int'(cur_slot) + k) % NUM_SLOTS;
                    if (pick < 0 && slot_st[idx] == ST_READY) pick = idx;
                end
                // A terminated current slot keeps its state; only a running one is demoted.
                if (pick >= 0 && slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_READY;
            end
            if (pick < 0) begin
                r.status = RES_NO_READY;
            end else begin
                cur_valid        = 1'b1;
                cur_slot         = SLOT_W'(pick);
                slot_st[pick]    = ST_RUNNING;
                r.slot_id        = ID_W'(pick);
                r.dispatch_entry = slot_addr[pick];
            end
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_st[i] == ST_RUNNING) begin
                r.running_valid = 1'b1;
                r.running_id    = ID_W'(i);
            end
        end
        return r;
    endfunction

    function automatic void add_req(logic [MODE_W-1:0] mode, logic [ENTRY_W-1:0] addr);
        pending_reqs.push_back(S_DATA_W'({addr, mode}));
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Request side: the predictor runs on every accepted request transfer. Result side: each
    // accepted result transfer is compared field by field with the oldest expectation.
    always @(posedge aclk) begin
        sched_res_t exp_r;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(predict_sched(s_tdata[MODE_W-1:0],
                                                     s_tdata[MODE_W +: ENTRY_W]));
            accepted_cnt <= accepted_cnt + 1;
            idle_phase   <= ((accepted_cnt + 1) / PHASE_LEN) % 4;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no request waiting for it: 0x%0h", m_tdata);
                err_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", 64'(exp_r.status), 64'(m_tdata[1:0]));
                check_field("slot_id", 64'(exp_r.slot_id), 64'(m_tdata[3:2]));
                check_field("dispatch_entry", 64'(exp_r.dispatch_entry), 64'(m_tdata[51:4]));
                check_field("running_valid", 64'(exp_r.running_valid), 64'(m_tdata[52]));
                check_field("running_id", 64'(exp_r.running_id), 64'(m_tdata[54:53]));
            end
        end
    end

    // Request driver. Idling phases rotate every PHASE_LEN transfers: none, sender idling at 58
    // percent, receiver stalling at 58 percent, then both at 10 percent.
    always @(negedge aclk) begin
        logic                next_valid;
        logic [S_DATA_W-1:0] next_data;
        logic                idle;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        idle = (idle_phase == 1 && $urandom_range(99) < 58) ||
               (idle_phase == 3 && $urandom_range(99) < 10);
        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_reqs.size() != 0 && !idle) begin
                next_data  = pending_reqs.pop_front();
                next_valid = 1'b1;
            end else begin
                next_valid = 1'b0;
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // Result receiver backpressure.
    always @(negedge aclk) begin
        logic stall;
        stall = (idle_phase == 2 && $urandom_range(99) < 58) ||
                (idle_phase == 3 && $urandom_range(99) < 10);
        m_tready <= aresetn && !stall;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [MODE_W-1:0] mode;
        int                pick;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_st[i]   = ST_UNUSED;
            slot_addr[i] = '0;
        end
        cur_valid = 1'b0;
        cur_slot  = '0;

        // Directed part. The empty table comes first, since slots are never freed.
        add_req(MODE_YIELD,  '0);                   // yield with nothing ready
        add_req(MODE_TERM,   '0);                   // terminate with no current task
        add_req(MODE_NONE,   '1);                   // unused mode leaves everything alone
        add_req(MODE_CREATE, '0);                   // slot 0, all-zero entry
        add_req(MODE_YIELD,  '1);                   // first dispatch with no current task
        add_req(MODE_YIELD,  '0);                   // the only task is running: nothing ready
        add_req(MODE_CREATE, '1);                   // slot 1, all-ones entry
        add_req(MODE_CREATE, 48'hAAAA_AAAA_AAAA);   // slot 2
        add_req(MODE_YIELD,  '0);                   // 0 demoted, 1 runs
        add_req(MODE_YIELD,  '0);                   // 2 runs
        add_req(MODE_YIELD,  '0);                   // wraps back to 0
        add_req(MODE_TERM,   '0);                   // 0 terminated, 1 runs
        add_req(MODE_CREATE, 48'h5555_5555_5555);   // slot 3 fills the table
        add_req(MODE_CREATE, 48'h0123_4567_89AB);   // table full
        add_req(MODE_YIELD,  '0);
        add_req(MODE_YIELD,  '0);
        add_req(MODE_YIELD,  '0);                   // skips the terminated slot 0
        add_req(MODE_NONE,   '0);
        add_req(MODE_TERM,   '1);
        add_req(MODE_YIELD,  '0);

        // Random part: mostly yields that rotate the live tasks. Terminations are rare until
        // the tail, where they use up the table so that yields from a terminated current
        // task and terminations with nothing ready get exercised too.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(99);
            if ((i < RANDOM_REQS - 60 && $urandom_range(249) == 0) ||
                (i >= RANDOM_REQS - 60 && pick < 25)) mode = MODE_TERM;
            else if (pick < 75) mode = MODE_YIELD;
            else if (pick < 88) mode = MODE_CREATE;
            else mode = MODE_NONE;
            add_req(mode, {16'($urandom), 32'($urandom)});
        end
        total_reqs = pending_reqs.size();

        // Reset must be rebuilt from scratch in the predictor copy above; the driver holds
        // the bus idle while aresetn is low.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (accepted_cnt < total_reqs) @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
